FILE: design/ahfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfd_pkg
// shared types and constants of the ascii header frame deframer
// ----------------------------------------------------------------------------
package ahfd_pkg;

    localparam int LEN_BITS = 24;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LEN   = 3'd1,
        PH_TITLE = 3'd2,
        PH_BODY  = 3'd3,
        PH_TRAIL = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CLS_UNKNOWN  = 3'd0,
        CLS_LOGIN    = 3'd1,
        CLS_PERSONAL = 3'd2,
        CLS_FRIENDS  = 3'd3,
        CLS_CHAT     = 3'd4,
        CLS_MAIL     = 3'd5
    } t_class;

    localparam logic [7:0] C_MARKER [16] = '{
        8'h50, 8'h41, 8'h43, 8'h4B, 8'h41, 8'h47, 8'h45, 8'h5F,
        8'h42, 8'h45, 8'h47, 8'h49, 8'h4E, 8'h20, 8'h20, 8'h20
    };

    localparam logic [7:0] C_CHAR_P    = 8'h50;
    localparam logic [7:0] C_CHAR_ZERO = 8'h30;
    localparam logic [7:0] C_CHAR_NINE = 8'h39;

    localparam logic [63:0] C_NAME_LOGIN    = 64'("LOGIN");
    localparam logic [63:0] C_NAME_PERSONAL = 64'("PERSONAL");
    localparam logic [63:0] C_NAME_FRIENDS  = 64'("FRIENDS");
    localparam logic [63:0] C_NAME_CHAT     = 64'("CHAT");
    localparam logic [63:0] C_NAME_MAIL     = 64'("MAIL");

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_word;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] body;
        t_class     cls;
        logic       last;
    } t_result;

endpackage : ahfd_pkg
`default_nettype wire

FILE: design/ascii_header_frame_deframer_core.sv
// path: an accepted byte waits in the input register; its result word is held in the result register
// throughput: one byte per cycle while the result side takes words; a waiting
//   result word holds the state machine and the input register takes one more byte
// reset: synchronous active-low, returns to marker hunt, max length 65552,
//   no clearing pass
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_header_frame_deframer_core
// finds the text marker, checks the decimal length, classifies the title and
// passes body bytes out tagged with the title class
// ----------------------------------------------------------------------------
module ascii_header_frame_deframer_core
    import ahfd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // rx_byte
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [7:0]               m_axis_tdata,   // body_byte
    output logic [4:0]               m_axis_tuser,   // result_kind, title_class
    output logic                     m_axis_tlast,   // last_of_frame
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [LEN_BITS-1:0] i_cfg_data      // max_frame_length
);

    t_byte_word in_word;
    logic       take;
    t_result    res;

    ahfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_take  (take),
        .o_word  (in_word)
    );

    ahfd_frame_ctrl u_frame_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (in_word),
        .o_take      (take),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = res.body;
    assign m_axis_tuser = {res.cls, res.kind};
    assign m_axis_tlast = res.last;

    // error words close the frame and carry no class
    a_error_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] == KIND_ERROR)
            |-> (m_axis_tlast && m_axis_tuser[4:2] == CLS_UNKNOWN && m_axis_tdata == 8'd0))
        else $error("error word malformed");

    // an empty frame is one word that is also the last
    a_empty_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] == KIND_EMPTY) |-> m_axis_tlast)
        else $error("empty frame word without last");

    // nothing leaves the block right after reset
    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word right after reset");

endmodule : ascii_header_frame_deframer_core
`default_nettype wire

FILE: design/ahfd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfd_in_stage
// input register of the byte stream, refilled in the cycle it is drained
// ----------------------------------------------------------------------------
module ahfd_in_stage
    import ahfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    input  wire logic       i_take,
    output t_byte_word      o_word
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.data  = r_data;

endmodule : ahfd_in_stage
`default_nettype wire

FILE: design/ahfd_title_class.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfd_title_class
// trims white space off a 16-byte title and matches it against the known names
// ----------------------------------------------------------------------------
module ahfd_title_class
    import ahfd_pkg::*;
(
    input  wire logic [7:0] i_title [16],
    output t_class          o_class
);

    logic [15:0] ws;
    logic [16:0] lead_ok;
    logic [16:0] trail_ok;
    logic        hit_login;
    logic        hit_personal;
    logic        hit_friends;
    logic        hit_chat;
    logic        hit_mail;

    function automatic logic name_at(input logic [7:0] title [16], input int start,
                                     input logic [63:0] name, input int len);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i < len) begin
                if (title[start + i] != name[8 * (len - 1 - i) +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            ws[i] = (i_title[i] == 8'd32) || (i_title[i] >= 8'd9 && i_title[i] <= 8'd13);
        end
    end

    // lead_ok[s]: bytes below s all white; trail_ok[e]: bytes from e up all white
    always_comb begin
        for (int s = 0; s <= 16; s++) begin
            lead_ok[s]  = ((ws | ~((17'd1 << s) - 17'd1)) & 17'h0FFFF) == 17'h0FFFF
                          || s == 0;
            trail_ok[s] = ((ws & ~((17'd1 << s) - 17'd1)) & 17'h0FFFF)
                          == (17'h0FFFF & ~((17'd1 << s) - 17'd1));
        end
    end

    always_comb begin
        hit_login    = 1'b0;
        hit_personal = 1'b0;
        hit_friends  = 1'b0;
        hit_chat     = 1'b0;
        hit_mail     = 1'b0;
        for (int s = 0; s <= 11; s++) begin
            if (lead_ok[s] && trail_ok[s + 5] && name_at(i_title, s, C_NAME_LOGIN, 5)) begin
                hit_login = 1'b1;
            end
        end
        for (int s = 0; s <= 8; s++) begin
            if (lead_ok[s] && trail_ok[s + 8] && name_at(i_title, s, C_NAME_PERSONAL, 8)) begin
                hit_personal = 1'b1;
            end
        end
        for (int s = 0; s <= 9; s++) begin
            if (lead_ok[s] && trail_ok[s + 7] && name_at(i_title, s, C_NAME_FRIENDS, 7)) begin
                hit_friends = 1'b1;
            end
        end
        for (int s = 0; s <= 12; s++) begin
            if (lead_ok[s] && trail_ok[s + 4] && name_at(i_title, s, C_NAME_CHAT, 4)) begin
                hit_chat = 1'b1;
            end
            if (lead_ok[s] && trail_ok[s + 4] && name_at(i_title, s, C_NAME_MAIL, 4)) begin
                hit_mail = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (hit_login) begin
            o_class = CLS_LOGIN;
        end else if (hit_personal) begin
            o_class = CLS_PERSONAL;
        end else if (hit_friends) begin
            o_class = CLS_FRIENDS;
        end else if (hit_chat) begin
            o_class = CLS_CHAT;
        end else if (hit_mail) begin
            o_class = CLS_MAIL;
        end else begin
            o_class = CLS_UNKNOWN;
        end
    end

endmodule : ahfd_title_class
`default_nettype wire

FILE: design/ahfd_frame_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahfd_frame_ctrl
// frame state machine: marker hunt, length digits, title, body and trailer,
// with the result register on its output
// ----------------------------------------------------------------------------
module ahfd_frame_ctrl
    import ahfd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_byte_word          i_word,
    output logic                     o_take,
    input  wire logic                i_cfg_valid,
    input  wire logic [LEN_BITS-1:0] i_cfg_data,
    output logic                     o_res_valid,
    input  wire logic                i_res_ready,
    output t_result                  o_res
);

    localparam int ACC_W = LEN_BITS + 1;
    localparam int MUL_W = LEN_BITS + 4;
    localparam logic [ACC_W-1:0] LEN_SAT = {1'b1, {LEN_BITS{1'b0}}};
    localparam logic [ACC_W-1:0] LEN_MIN = ACC_W'(16);
    localparam logic [LEN_BITS-1:0] REM_STEP = LEN_BITS'(16);
    localparam logic [LEN_BITS-1:0] MAX_RESET = LEN_BITS'(65552);

    t_phase              r_phase;
    t_phase              n_phase;
    logic [3:0]          r_pos;
    logic [3:0]          n_pos;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic                r_bad;
    logic                n_bad;
    logic [7:0]          r_title [15];
    logic [2:0]          r_class;
    logic [2:0]          n_class;
    logic [LEN_BITS-1:0] r_rem;
    logic [LEN_BITS-1:0] n_rem;
    logic [LEN_BITS-1:0] r_max;
    logic                r_out_valid;
    t_result             r_out;

    logic                process;
    logic [7:0]          rx;
    logic                pos_end;
    logic                marker_hit;
    logic                is_digit;
    logic [MUL_W-1:0]    acc_sum;
    logic [ACC_W-1:0]    len_new;
    logic                bad_new;
    logic                len_fail;
    logic                rem_small;
    logic [LEN_BITS-1:0] rem_dec;
    logic                body_last;
    logic [7:0]          title_view [16];
    t_class              title_cls;
    logic                title_we;
    logic                res_valid;
    t_result             res;

    assign o_take  = !r_out_valid || i_res_ready;
    assign process = i_word.valid && o_take;
    assign rx      = i_word.data;
    assign pos_end = (r_pos == 4'd15);

    assign marker_hit = (rx == C_MARKER[r_pos]);
    assign is_digit   = (rx >= C_CHAR_ZERO) && (rx <= C_CHAR_NINE);
    assign acc_sum    = {3'b000, r_acc} * MUL_W'(10) + MUL_W'(rx - C_CHAR_ZERO);

    always_comb begin
        if (!is_digit) begin
            len_new = r_acc;
        end else if (acc_sum > MUL_W'(LEN_SAT)) begin
            len_new = LEN_SAT;
        end else begin
            len_new = acc_sum[ACC_W-1:0];
        end
    end

    assign bad_new   = r_bad || !is_digit;
    assign len_fail  = bad_new || (len_new < LEN_MIN) || (len_new > {1'b0, r_max});
    assign rem_small = (r_rem <= REM_STEP);
    assign rem_dec   = (r_rem != '0) ? r_rem - LEN_BITS'(1) : '0;
    assign body_last = (rem_dec == '0);

    always_comb begin
        for (int i = 0; i < 15; i++) begin
            title_view[i] = r_title[i];
        end
        title_view[15] = rx;
    end

    ahfd_title_class u_title_class (
        .i_title (title_view),
        .o_class (title_cls)
    );

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT: begin
                if (marker_hit && pos_end) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (pos_end) begin
                    n_phase = len_fail ? PH_HUNT : PH_TITLE;
                end
            end
            PH_TITLE: begin
                if (pos_end) begin
                    n_phase = rem_small ? PH_TRAIL : PH_BODY;
                end
            end
            PH_BODY: begin
                if (body_last) begin
                    n_phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                if (pos_end) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_bad     = r_bad;
        n_class   = r_class;
        n_rem     = r_rem;
        title_we  = 1'b0;
        res_valid = 1'b0;
        res.kind  = KIND_BODY;
        res.body  = '0;
        res.cls   = CLS_UNKNOWN;
        res.last  = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (marker_hit) begin
                    n_pos = r_pos + 4'd1;
                    if (pos_end) begin
                        n_acc = '0;
                        n_bad = 1'b0;
                    end
                end else begin
                    n_pos = (rx == C_CHAR_P) ? 4'd1 : 4'd0;
                end
            end
            PH_LEN: begin
                n_acc = len_new;
                n_bad = bad_new;
                n_pos = r_pos + 4'd1;
                if (pos_end) begin
                    if (len_fail) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_ERROR;
                        res.last  = 1'b1;
                    end else begin
                        n_rem = len_new[LEN_BITS-1:0];
                    end
                end
            end
            PH_TITLE: begin
                title_we = !pos_end;
                n_pos    = r_pos + 4'd1;
                if (pos_end) begin
                    n_class = title_cls;
                    if (rem_small) begin
                        n_rem     = '0;
                        res_valid = 1'b1;
                        res.kind  = KIND_EMPTY;
                        res.cls   = title_cls;
                        res.last  = 1'b1;
                    end else begin
                        n_rem = r_rem - REM_STEP;
                    end
                end
            end
            PH_BODY: begin
                n_rem     = rem_dec;
                res_valid = 1'b1;
                res.kind  = KIND_BODY;
                res.body  = rx;
                res.cls   = t_class'(r_class);
                res.last  = body_last;
                if (body_last) begin
                    n_pos = 4'd0;
                end
            end
            PH_TRAIL: begin
                n_pos = r_pos + 4'd1;
            end
            default: begin
                n_pos = 4'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_acc   <= '0;
            r_bad   <= 1'b0;
            r_class <= '0;
            r_rem   <= '0;
        end else if (process) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_bad   <= n_bad;
            r_class <= n_class;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && title_we) begin
            r_title[r_pos] <= rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RESET;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= process && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule : ahfd_frame_ctrl
`default_nettype wire
